### rtl/core/r2fft_pkg.sv
`default_nettype none
package r2fft_pkg;
    localparam int MAX_POINTS = 64;
    localparam int LOG_MAX = 6;
    localparam int ACC_W = 24;
    localparam int TW_W = 16;

    // round(32768*cos(2*pi*k/64)), k = 0..16
    function automatic logic signed [17:0] qcos(input logic [4:0] k);
        logic signed [17:0] r;
        case (k)
            5'd0: r = 18'sd32768;
            5'd1: r = 18'sd32610;
            5'd2: r = 18'sd32138;
            5'd3: r = 18'sd31357;
            5'd4: r = 18'sd30274;
            5'd5: r = 18'sd28899;
            5'd6: r = 18'sd27246;
            5'd7: r = 18'sd25330;
            5'd8: r = 18'sd23170;
            5'd9: r = 18'sd20788;
            5'd10: r = 18'sd18205;
            5'd11: r = 18'sd15447;
            5'd12: r = 18'sd12540;
            5'd13: r = 18'sd9512;
            5'd14: r = 18'sd6393;
            5'd15: r = 18'sd3212;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    // twiddle for k in 0..31, cosine saturated to fit Q1.15
    function automatic logic signed [TW_W-1:0] tw_re(input logic [4:0] k);
        logic signed [17:0] c;
        if (k <= 5'd16)
            c = qcos(k);
        else
            c = -qcos(5'd0 - k);
        if (c > 18'sd32767)
            c = 18'sd32767;
        return c[TW_W-1:0];
    endfunction

    function automatic logic signed [TW_W-1:0] tw_im(input logic [4:0] k);
        logic signed [17:0] s;
        if (k <= 5'd16)
            s = qcos(5'd16 - k);
        else
            s = qcos(k - 5'd16);
        s = -s;
        return s[TW_W-1:0];
    endfunction
endpackage
`default_nettype wire

### rtl/core/r2fft_ram.sv
`default_nettype none
module r2fft_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/core/radix2_fft.sv
// channel   dir  tdata fields (low bit up)                      tuser/tlast
// s_axis    in   sample_re[15:0], sample_im[31:16]                -
// m_axis    out  bin_re[23:0], bin_im[47:24], bin_index[53:48]    tlast=last_bin
// cfg       in   log_points[2:0] on cfg_wdata, cfg_we
// loading accepts one sample per cycle; after the last sample of a frame the
// butterfly unit steps each of the (N/2)*log2N butterflies through read b,
// read a, multiply, write a and write b, limited by the single read and write
// port of the sample ram, then emits N output items, each through read and output
// reset clears control and load count and sets log_points to 6
// s_axis_tready is low while the frame is transformed and emitted; an output
// stall holds the bin in the output register
`default_nettype none
module radix2_fft
    import r2fft_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // sample_re, sample_im
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // bin_re, bin_im, bin_index, zero pad
    output logic             m_axis_tlast    // last_bin
);
    localparam int AW = 6;
    localparam int DW = 2 * ACC_W;

    typedef enum logic [2:0] {S_LOAD, S_RDB, S_RDA, S_MUL, S_WRA, S_WRB, S_OUT_RD, S_OUT}
        state_t;
    state_t state_reg;

    logic [2:0] log_reg;
    logic [AW:0] cnt_reg;        // load count, then output index
    logic [2:0] stage_reg;       // current stage 1..l
    logic [AW-1:0] bfly_reg;     // butterfly number within stage
    logic [2:0] l_eff;
    logic [AW:0] n_pts;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    r2fft_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        l_eff = log_reg;
        if (l_eff < 3'd1)
            l_eff = 3'd1;
        if (l_eff > 3'd6)
            l_eff = 3'd6;
        n_pts = (AW + 1)'(1) << l_eff;
    end

    // bit reversed load address
    logic [AW-1:0] rev_addr;
    always_comb
    begin
        logic [AW-1:0] c;
        c = cnt_reg[AW-1:0];
        rev_addr = '0;
        for (int i = 0; i < AW; i++)
            if (3'(i) < l_eff)
                rev_addr[l_eff - 3'd1 - 3'(i)] = c[i];
    end

    // butterfly addressing: half = 2^(s-1), j = bfly mod half
    logic [AW-1:0] half, jj, addr_a, addr_b, grp;
    logic [4:0] tw_k;
    always_comb
    begin
        half = AW'(1) << (stage_reg - 3'd1);
        jj = bfly_reg & (half - AW'(1));
        grp = (bfly_reg >> (stage_reg - 3'd1)) << stage_reg;
        addr_a = grp | jj;
        addr_b = addr_a | half;
        tw_k = 5'((jj << (3'd6 - stage_reg)) & AW'(31));
    end

    logic signed [ACC_W-1:0] br_reg, bi_reg, ar_reg, ai_reg;
    logic signed [TW_W-1:0] wr_reg, wi_reg;
    logic signed [ACC_W+TW_W:0] pr_reg, pi_reg;
    logic signed [ACC_W-1:0] tr, ti;
    logic signed [ACC_W+TW_W:0] rr, ri;

    always_comb
    begin
        rr = pr_reg + (ACC_W + TW_W + 1)'(16384);
        ri = pi_reg + (ACC_W + TW_W + 1)'(16384);
        tr = ACC_W'(rr >>> 15);
        ti = ACC_W'(ri >>> 15);
    end

    logic s_fire, m_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == S_LOAD);

    always_comb
    begin
        we = 1'b0;
        waddr = rev_addr;
        wdata = {{(ACC_W-16){s_axis_tdata[31]}}, s_axis_tdata[31:16],
                 {(ACC_W-16){s_axis_tdata[15]}}, s_axis_tdata[15:0]};
        raddr = addr_b;
        unique case (state_reg)
            S_LOAD: we = s_fire;
            S_RDB: raddr = addr_b;
            S_RDA: raddr = addr_a;
            S_WRA:
            begin
                we = 1'b1;
                waddr = addr_a;
                wdata = {ai_reg + ti, ar_reg + tr};
            end
            S_WRB:
            begin
                we = 1'b1;
                waddr = addr_b;
                wdata = {ai_reg - ti, ar_reg - tr};
            end
            S_OUT_RD, S_OUT: raddr = cnt_reg[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            log_reg <= 3'd6;
            cnt_reg <= '0;
            stage_reg <= 3'd1;
            bfly_reg <= '0;
            m_axis_tvalid <= 1'b0;
            m_axis_tlast <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                log_reg <= cfg_wdata;
                cnt_reg <= '0;
            end
            unique case (state_reg)
                S_LOAD:
                    if (s_fire && !cfg_we)
                    begin
                        if (cnt_reg + 1'b1 >= n_pts)
                        begin
                            cnt_reg <= '0;
                            stage_reg <= 3'd1;
                            bfly_reg <= '0;
                            state_reg <= S_RDB;
                        end
                        else
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                S_RDB: state_reg <= S_RDA;
                S_RDA:
                begin
                    br_reg <= rdata[ACC_W-1:0];
                    bi_reg <= rdata[DW-1:ACC_W];
                    wr_reg <= tw_re(tw_k);
                    wi_reg <= tw_im(tw_k);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    ar_reg <= rdata[ACC_W-1:0];
                    ai_reg <= rdata[DW-1:ACC_W];
                    pr_reg <= br_reg * wr_reg - bi_reg * wi_reg;
                    pi_reg <= bi_reg * wr_reg + br_reg * wi_reg;
                    state_reg <= S_WRA;
                end
                S_WRA: state_reg <= S_WRB;
                S_WRB:
                    if ({1'b0, bfly_reg} + 1'b1 >= (n_pts >> 1))
                    begin
                        bfly_reg <= '0;
                        if (stage_reg >= l_eff)
                        begin
                            cnt_reg <= '0;
                            state_reg <= S_OUT_RD;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 3'd1;
                            state_reg <= S_RDB;
                        end
                    end
                    else
                    begin
                        bfly_reg <= bfly_reg + 1'b1;
                        state_reg <= S_RDB;
                    end
                S_OUT_RD:
                    if (!m_axis_tvalid || m_fire)
                    begin
                        m_axis_tvalid <= 1'b0;
                        state_reg <= S_OUT;
                    end
                S_OUT:
                begin
                    m_axis_tdata <= {2'b00, cnt_reg[AW-1:0], rdata};
                    m_axis_tvalid <= 1'b1;
                    m_axis_tlast <= (cnt_reg + 1'b1 == n_pts);
                    if (cnt_reg + 1'b1 == n_pts)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= S_OUT_RD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
            if (m_fire && state_reg != S_OUT_RD)
                m_axis_tvalid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

### dv/fft_checker.sv
module fft_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [55:0] m_axis_tdata,
    input  wire logic        m_axis_tlast,
    output int               fail_count,
    output int               bins_pending,
    output int               bins_seen,
    output int               frames_done
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        last;
        logic [5:0]  index;
        logic [23:0] im;
        logic [23:0] re;
    } fft_bin_t;

    localparam int QCOS [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                                 23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    longint    pts_re [64];
    longint    pts_im [64];
    int        frame_fill;
    logic [2:0] len_log;
    fft_bin_t  bin_queue [$];

    function automatic longint round_q15(longint p);
        longint q;
        q = p + 64'sd16384;
        return q >>> 15;
    endfunction

    function automatic longint wrap24(longint v);
        logic [23:0] t;
        t = v[23:0];
        return longint'($signed(t));
    endfunction

    task automatic transform_frame(int lg);
        int n;
        int half;
        int k;
        longint c;
        longint s;
        longint tr;
        longint ti;
        longint ur;
        longint ui;
        fft_bin_t b;
        n = 1 << lg;
        for (int st = 1; st <= lg; st++)
        begin
            half = 1 << (st - 1);
            for (int i = 0; i < n; i += 2 * half)
            begin
                for (int j = 0; j < half; j++)
                begin
                    k = (j * (64 >> st)) & 31;
                    if (k <= 16)
                    begin
                        c = QCOS[k];
                        s = QCOS[16 - k];
                    end
                    else
                    begin
                        c = -QCOS[32 - k];
                        s = QCOS[k - 16];
                    end
                    if (c > 32767)
                        c = 32767;
                    s = -s;
                    tr = round_q15(pts_re[i+j+half] * c - pts_im[i+j+half] * s);
                    ti = round_q15(pts_im[i+j+half] * c + pts_re[i+j+half] * s);
                    ur = pts_re[i+j];
                    ui = pts_im[i+j];
                    pts_re[i+j] = wrap24(ur + tr);
                    pts_im[i+j] = wrap24(ui + ti);
                    pts_re[i+j+half] = wrap24(ur - tr);
                    pts_im[i+j+half] = wrap24(ui - ti);
                end
            end
        end
        for (int m = 0; m < n; m++)
        begin
            b.re = pts_re[m][23:0];
            b.im = pts_im[m][23:0];
            b.index = m[5:0];
            b.last = (m == n - 1);
            bin_queue.push_back(b);
        end
    endtask

    function automatic int active_log();
        if (len_log < 1)
            return 1;
        if (len_log > 6)
            return 6;
        return len_log;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        fft_bin_t got;
        fft_bin_t want;
        int lg;
        int addr;
        if (!rst_n)
        begin
            len_log <= 3'd6;
            frame_fill = 0;
            fail_count <= 0;
            bins_seen <= 0;
            frames_done <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_log <= cfg_wdata;
                frame_fill = 0;
            end
            else if (s_axis_tvalid && s_axis_tready)
            begin
                lg = active_log();
                addr = 0;
                for (int i = 0; i < lg; i++)
                    if ((frame_fill >> i) & 1)
                        addr |= 1 << (lg - 1 - i);
                pts_re[addr] = longint'($signed(s_axis_tdata[15:0]));
                pts_im[addr] = longint'($signed(s_axis_tdata[31:16]));
                frame_fill++;
                if (frame_fill == (1 << lg))
                begin
                    frame_fill = 0;
                    transform_frame(lg);
                    frames_done <= frames_done + 1;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tlast, m_axis_tdata[53:0]};
                bins_seen <= bins_seen + 1;
                if (bin_queue.size() == 0)
                begin
                    $error("unexpected bin item %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = bin_queue.pop_front();
                    if (got.re !== want.re)
                        $error("bin_re expected %h got %h", want.re, got.re);
                    if (got.im !== want.im)
                        $error("bin_im expected %h got %h", want.im, got.im);
                    if (got.index !== want.index)
                        $error("bin_index expected %0d got %0d", want.index, got.index);
                    if (got.last !== want.last)
                        $error("last_bin expected %b got %b", want.last, got.last);
                    if (got !== want)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

    assign bins_pending = bin_queue.size();
endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_wdata = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          bins_pending;
    int          bins_seen;
    int          frames_done;
    bit          calm_tail = 0;
    bit          hold_sink = 0;
    int          sent = 0;

    always #1 clk = ~clk;

    radix2_fft DUT (.*);

    fft_checker checker_i (.*);

    // sink side: held off while hold_sink is set, else random stalls, then free running near the end
    initial
    begin
        int gap;
        @(negedge clk);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 0;
                @(negedge clk);
            end
            else if (!calm_tail && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 16);
                m_axis_tready <= 0;
                repeat (gap) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    // tvalid stays high from one item to the next unless a random gap comes first; callers drop it after a run
    task automatic send_sample(logic [15:0] re, logic [15:0] im);
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {im, re};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain_and_set(logic [2:0] lg);
        while (bins_pending != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= lg;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frames(int frames, int n);
        for (int f = 0; f < frames; f++)
            for (int i = 0; i < n; i++)
                send_sample(rand_val(), rand_val());
    endtask

    initial
    begin
        int n;
        logic [2:0] lg;
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // directed: full-scale 64-point frame at reset length, then two 2-point frames of extreme and small values
        for (int i = 0; i < 64; i++)
            send_sample(i[0] ? 16'h8000 : 16'h7fff, i[1] ? 16'h7fff : 16'h8000);
        s_axis_tvalid <= 0;
        drain_and_set(3'd1);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'h0000, 16'hffff);
        s_axis_tvalid <= 0;
        // out-of-range lengths clamp; partial frame dropped by the write
        drain_and_set(3'd0);
        send_frames(2, 2);
        send_sample(16'h1234, 16'h4321);
        s_axis_tvalid <= 0;
        drain_and_set(3'd7);
        send_frames(1, 64);
        s_axis_tvalid <= 0;
        // sink held off while samples keep coming
        drain_and_set(3'd2);
        hold_sink = 1;
        fork
            send_frames(6, 4);
            begin
                repeat (400) @(negedge clk);
                hold_sink = 0;
            end
        join
        s_axis_tvalid <= 0;
        // random part over all lengths, mostly short
        while (sent < 330)
        begin
            n = $urandom_range(0, 9);
            lg = n > 7 ? 3'($urandom_range(1, 5)) : 3'(n);
            drain_and_set(lg);
            n = 1 << (lg < 1 ? 1 : (lg > 6 ? 6 : lg));
            send_frames($urandom_range(1, 3), n);
            s_axis_tvalid <= 0;
        end
        calm_tail = 1;
        drain_and_set(3'd3);
        send_frames(4, 8);
        s_axis_tvalid <= 0;
        while (bins_pending != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
        $display("covered %0d samples in %0d frames, %0d bins checked, lengths 2..64",
                 sent, frames_done, bins_seen);
        if (fail_count == 0 && bins_pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: errors");
        $finish;
    end
endmodule

### filelist.f
rtl/core/r2fft_pkg.sv
rtl/core/r2fft_ram.sv
rtl/core/radix2_fft.sv
dv/fft_checker.sv
dv/tb.sv
